// ===== rtl/core/erng_pkg.sv =====
// Shared constants and types for the ultrasonic echo ranger.
// Register indexes, reset values, distance scaling and the distance-tracker control struct.
// No dependencies.
package erng_pkg;

	// defaults for the top-level parameters
	localparam int DEF_NUM_CHANNELS = 7;
	localparam int DEF_COUNT_WIDTH  = 16;

	// configuration register widths, indexes and reset values
	localparam int TMO_W  = 16;
	localparam int TRIG_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIG_FRONT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIG_BACK  = 2'd2;

	localparam logic [TMO_W-1:0]  TIMEOUT_RST    = 16'd1300;
	localparam logic [TRIG_W-1:0] TRIG_FRONT_RST = 8'd2;
	localparam logic [TRIG_W-1:0] TRIG_BACK_RST  = 8'd3;

	// opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// distance = count * 5 * 34 / 2000 = count * 17 / 200, saturating
	localparam int DIST_W   = 13;
	localparam int DIST_MUL = (5 * 34) / 10;
	localparam int DIST_DIV = 2000 / 10;
	localparam int REM_W    = 8;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// control from the sequencer to the distance tracker
	typedef struct packed {
		logic clr;   // restart at count zero
		logic step;  // count advances by one
	} erng_dist_ctl_t;

endpackage

// ===== rtl/core/erng_dist.sv =====
// Running distance tracker: keeps count*17/200 as quotient and remainder.
// Advances by one count per step, so no multiplier or divider is needed.
// Depends on erng_pkg.
module erng_dist
	import erng_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  erng_dist_ctl_t       ctl,
	output logic [DIST_W-1:0]    dist_next
);

	logic [DIST_W-1:0] quo_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W:0]    rem_sum;
	logic              wrap;
	logic [REM_W-1:0]  rem_nx;
	logic [DIST_W-1:0] quo_nx;

	// one count adds 17/200: bump the remainder, carry into the quotient
	always_comb begin
		rem_sum = {1'b0, rem_q} + (REM_W+1)'(DIST_MUL);
		wrap    = rem_sum >= (REM_W+1)'(DIST_DIV);
		rem_nx  = wrap ? REM_W'(rem_sum - (REM_W+1)'(DIST_DIV)) : REM_W'(rem_sum);
		quo_nx  = (wrap && quo_q != DIST_MAX) ? quo_q + 1'b1 : quo_q;
	end

	// distance after this request's count update
	assign dist_next = ctl.step ? quo_nx : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
			rem_q <= '0;
		end else if (ctl.clr) begin
			quo_q <= '0;
			rem_q <= '0;
		end else if (ctl.step) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

endmodule

// ===== rtl/core/erng_fsm.sv =====
// Measurement sequencer: idle, trigger pulse, echo wait, echo count.
// Processes one request per fire and presents the state after it.
// Depends on erng_pkg and erng_dist.
module erng_fsm
	import erng_pkg::*;
#(
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
	parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
	localparam int CHW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
	localparam int CMPW = (COUNT_WIDTH > TMO_W) ? COUNT_WIDTH : TMO_W
)
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fire,
	input  logic                    op,
	input  logic [CHW-1:0]          channel,
	input  logic [NUM_CHANNELS-1:0] echo_levels,
	input  logic [TMO_W-1:0]        timeout_count,
	input  logic [TRIG_W-1:0]       trig_front,
	input  logic [TRIG_W-1:0]       trig_back,
	output logic [NUM_CHANNELS-1:0] trigger_nx,
	output logic                    busy_nx,
	output logic                    done_nx,
	output logic [DIST_W-1:0]       distance_nx,
	output logic                    timed_out_nx,
	output logic [CHW-1:0]          channel_nx
);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_PULSE = 2'd1;
	localparam logic [1:0] PH_WAIT  = 2'd2;
	localparam logic [1:0] PH_COUNT = 2'd3;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic [1:0]             phase_q, phase_d;
	logic [CHW-1:0]         chan_q, chan_d;
	logic [TRIG_W-1:0]      pulse_q, pulse_d, pulse_inc;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
	logic [DIST_W-1:0]      dist_q, dist_d;
	logic                   tmo_q, tmo_d;
	logic                   done;
	logic                   echo_high;
	logic [TRIG_W-1:0]      pulse_len;
	erng_dist_ctl_t         dctl;
	logic [DIST_W-1:0]      dist_next;

	erng_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (dctl),
		.dist_next (dist_next)
	);

	assign echo_high = echo_levels[chan_q];
	assign pulse_len = (chan_q == CHW'(NUM_CHANNELS - 1)) ? trig_back : trig_front;
	assign pulse_inc = (pulse_q != '1) ? pulse_q + 1'b1 : pulse_q;
	assign cnt_inc   = (cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;

	// next state for the current request
	always_comb begin
		phase_d = phase_q;
		chan_d  = chan_q;
		pulse_d = pulse_q;
		cnt_d   = cnt_q;
		dist_d  = dist_q;
		tmo_d   = tmo_q;
		done    = 1'b0;
		dctl    = '0;
		if (op == OP_START) begin
			// start is ignored while busy or for an unknown channel
			if (phase_q == PH_IDLE && {1'b0, channel} < (CHW+1)'(NUM_CHANNELS)) begin
				chan_d   = channel;
				pulse_d  = '0;
				cnt_d    = '0;
				phase_d  = PH_PULSE;
				dctl.clr = 1'b1;
			end
		end else begin
			case (phase_q)
				PH_PULSE: begin
					pulse_d = pulse_inc;
					if (pulse_inc >= pulse_len)
						phase_d = PH_WAIT;
				end
				PH_WAIT: begin
					if (echo_high) begin
						cnt_d    = '0;
						phase_d  = PH_COUNT;
						dctl.clr = 1'b1;
					end
				end
				PH_COUNT: begin
					cnt_d     = cnt_inc;
					dctl.step = cnt_q != CNT_MAX;
					// timeout wins over a falling echo; a saturated count also times out
					if (CMPW'(cnt_inc) > CMPW'(timeout_count) || cnt_inc == CNT_MAX) begin
						phase_d = PH_IDLE;
						done    = 1'b1;
						tmo_d   = 1'b1;
						dist_d  = dist_next;
					end else if (!echo_high) begin
						phase_d = PH_IDLE;
						done    = 1'b1;
						tmo_d   = 1'b0;
						dist_d  = dist_next;
					end
				end
				default: begin
				end
			endcase
		end
		if (!fire)
			dctl = '0;
	end

	// state after this request, for the result register
	always_comb begin
		trigger_nx   = (phase_d == PH_PULSE) ? (NUM_CHANNELS'(1) << chan_d) : '0;
		busy_nx      = phase_d != PH_IDLE;
		done_nx      = done;
		distance_nx  = dist_d;
		timed_out_nx = tmo_d;
		channel_nx   = chan_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			chan_q  <= '0;
			pulse_q <= '0;
			cnt_q   <= '0;
			dist_q  <= '0;
			tmo_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			chan_q  <= chan_d;
			pulse_q <= pulse_d;
			cnt_q   <= cnt_d;
			dist_q  <= dist_d;
			tmo_q   <= tmo_d;
		end
	end

endmodule

// ===== rtl/core/ultrasonic_echo_ranger.sv =====
// Multi-channel ultrasonic echo ranger: input register, sequencer, result register.
// Results are registered in the result register after the input register.
// The sequencer sustains one request per cycle while the result is not stalled.
// Reset (arst_n low, asynchronous) clears the pipeline valids and the sequencer state
// and loads the register defaults: timeout 1300, front trigger 2, back trigger 3.
// Depends on erng_pkg and erng_fsm.
module ultrasonic_echo_ranger
	import erng_pkg::*;
#(
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
	parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
	localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
)
(
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// request channel
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic                    op,
	input  logic [CHW-1:0]          channel,
	input  logic [NUM_CHANNELS-1:0] echo_levels,
	// result channel
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic [NUM_CHANNELS-1:0] trigger_lines,
	output logic                    busy_res,
	output logic                    done_res,
	output logic [DIST_W-1:0]       distance,
	output logic                    timed_out,
	output logic [CHW-1:0]          measured_channel
);

	logic [TMO_W-1:0]        tmo_q;
	logic [TRIG_W-1:0]       trig_front_q, trig_back_q;
	logic                    valid_s1;
	logic                    op_s1;
	logic [CHW-1:0]          chan_s1;
	logic [NUM_CHANNELS-1:0] echo_s1;
	logic                    res_valid_q;
	logic [NUM_CHANNELS-1:0] trig_q;
	logic                    busy_q, done_q, tmo_res_q;
	logic [DIST_W-1:0]       dist_q;
	logic [CHW-1:0]          mchan_q;
	logic                    adv, fire;
	logic [NUM_CHANNELS-1:0] trigger_nx;
	logic                    busy_nx, done_nx, timed_out_nx;
	logic [DIST_W-1:0]       distance_nx;
	logic [CHW-1:0]          channel_nx;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_q        <= TIMEOUT_RST;
			trig_front_q <= TRIG_FRONT_RST;
			trig_back_q  <= TRIG_BACK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TIMEOUT:    tmo_q        <= cfg_data[TMO_W-1:0];
				CFG_TRIG_FRONT: trig_front_q <= cfg_data[TRIG_W-1:0];
				CFG_TRIG_BACK:  trig_back_q  <= cfg_data[TRIG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// handshake: result register frees up, stage 1 moves on
	assign adv       = !res_valid_q || !res_stall;
	assign fire      = valid_s1 && adv;
	assign req_stall = valid_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!valid_s1 || adv)
			valid_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			op_s1   <= op;
			chan_s1 <= channel;
			echo_s1 <= echo_levels;
		end
	end

	erng_fsm #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.op            (op_s1),
		.channel       (chan_s1),
		.echo_levels   (echo_s1),
		.timeout_count (tmo_q),
		.trig_front    (trig_front_q),
		.trig_back     (trig_back_q),
		.trigger_nx    (trigger_nx),
		.busy_nx       (busy_nx),
		.done_nx       (done_nx),
		.distance_nx   (distance_nx),
		.timed_out_nx  (timed_out_nx),
		.channel_nx    (channel_nx)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (adv)
			res_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			trig_q    <= trigger_nx;
			busy_q    <= busy_nx;
			done_q    <= done_nx;
			dist_q    <= distance_nx;
			tmo_res_q <= timed_out_nx;
			mchan_q   <= channel_nx;
		end
	end

	assign res_valid        = res_valid_q;
	assign trigger_lines    = trig_q;
	assign busy_res         = busy_q;
	assign done_res         = done_q;
	assign distance         = dist_q;
	assign timed_out        = tmo_res_q;
	assign measured_channel = mchan_q;

endmodule

// ===== rtl/core/erng_check.sv =====
// Port-level checker for the ultrasonic echo ranger, bound to the top level.
// Watches the result channel only. Depends on erng_pkg.
module erng_check
	import erng_pkg::*;
#(
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
	localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
)
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    res_valid,
	input logic                    res_stall,
	input logic [NUM_CHANNELS-1:0] trigger_lines,
	input logic                    busy_res,
	input logic                    done_res,
	input logic [DIST_W-1:0]       distance,
	input logic [CHW-1:0]          measured_channel
);

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(distance) && $stable(trigger_lines))
		else $error("result changed while stalled");

	// at most one trigger line high
	a_trig_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $onehot0(trigger_lines))
		else $error("more than one trigger line high");

	// a raised trigger belongs to the measured channel of a busy measurement
	a_trig_chan: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && trigger_lines != '0 |->
			busy_res && trigger_lines == (NUM_CHANNELS'(1) << measured_channel))
		else $error("trigger line does not match measured channel");

	// a finished measurement leaves the block idle with triggers low
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !busy_res && trigger_lines == '0)
		else $error("done reported while still busy");

endmodule

bind ultrasonic_echo_ranger erng_check #(
	.NUM_CHANNELS (NUM_CHANNELS)
) u_erng_check (.*);
